FILE: design/lob_pkg.sv
// Shared types and constants for the limit order book matcher.
// Holds the cell payload, the cell control group, the fill record and codes.
// No dependencies.
`default_nettype none
package lob_pkg;

  localparam int unsigned IdW      = 31;
  localparam int unsigned PriceW   = 32;
  localparam int unsigned QtyW     = 24;
  localparam int unsigned MaxFills = 32;
  localparam int unsigned FillIdxW = 5;
  localparam int unsigned FillCntW = 6;

  localparam logic CmdRest  = 1'b0;
  localparam logic CmdMatch = 1'b1;
  localparam logic SideBuy  = 1'b0;
  localparam logic SideSell = 1'b1;

  typedef enum logic [1:0] {
    KindRested = 2'd0,
    KindFill   = 2'd1,
    KindNoFill = 2'd2,
    KindReject = 2'd3
  } kind_e;

  typedef enum logic [4:0] {
    StIdle = 5'b00001,
    StIns  = 5'b00010,
    StWalk = 5'b00100,
    StEmit = 5'b01000,
    StFin  = 5'b10000
  } state_e;

  typedef struct packed {
    logic              valid;
    logic [PriceW-1:0] price;
    logic [QtyW-1:0]   qty;
    logic [IdW-1:0]    id;
  } cell_t;

  typedef struct packed {
    logic              ins;
    logic              pop;
    logic              dec;
    logic              is_bid;
    logic [PriceW-1:0] price;
    logic [QtyW-1:0]   qty;
    logic [IdW-1:0]    id;
    logic [QtyW-1:0]   dec_qty;
  } cell_ctrl_t;

  typedef struct packed {
    logic [IdW-1:0]    buyer;
    logic [IdW-1:0]    seller;
    logic [PriceW-1:0] price;
    logic [QtyW-1:0]   qty;
    logic              aggr;
  } fill_t;

endpackage
`default_nettype wire

FILE: design/lob_cell.sv
// One book entry of a side chain: insert shifts toward the tail, pop toward the head.
// Depends on lob_pkg.
`default_nettype none
module lob_cell (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire lob_pkg::cell_ctrl_t ctrl_i,
  input  wire logic               is_head_i,
  input  wire lob_pkg::cell_t     left_i,
  input  wire logic               left_after_i,
  input  wire lob_pkg::cell_t     right_i,
  output lob_pkg::cell_t          cell_o,
  output logic                    after_o
);

  logic                         valid_q, valid_d;
  logic [lob_pkg::PriceW-1:0]   price_q, price_d;
  logic [lob_pkg::QtyW-1:0]     qty_q, qty_d;
  logic [lob_pkg::IdW-1:0]      id_q, id_d;

  assign after_o = valid_q && (ctrl_i.is_bid ? (price_q >= ctrl_i.price)
                                             : (price_q <= ctrl_i.price));
  assign cell_o  = '{valid: valid_q, price: price_q, qty: qty_q, id: id_q};

  always_comb begin
    valid_d = valid_q;
    price_d = price_q;
    qty_d   = qty_q;
    id_d    = id_q;
    if (ctrl_i.ins && !after_o) begin
      if (left_after_i) begin
        valid_d = 1'b1;
        price_d = ctrl_i.price;
        qty_d   = ctrl_i.qty;
        id_d    = ctrl_i.id;
      end else begin
        valid_d = left_i.valid;
        price_d = left_i.price;
        qty_d   = left_i.qty;
        id_d    = left_i.id;
      end
    end else if (ctrl_i.pop) begin
      valid_d = right_i.valid;
      price_d = right_i.price;
      qty_d   = right_i.qty;
      id_d    = right_i.id;
    end else if (ctrl_i.dec && is_head_i) begin
      qty_d = qty_q - ctrl_i.dec_qty;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    price_q <= price_d;
    qty_q   <= qty_d;
    id_q    <= id_d;
  end

endmodule
`default_nettype wire

FILE: design/lob_side.sv
// One side of the book: a row of lob_cell entries kept sorted best first.
// Depends on lob_pkg and lob_cell.
`default_nettype none
module lob_side #(
  parameter int unsigned Depth = 32
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire lob_pkg::cell_ctrl_t ctrl_i,
  output lob_pkg::cell_t           head_o,
  output logic                     full_o
);

  lob_pkg::cell_t cells [Depth];
  logic           after [Depth];

  for (genvar i = 0; i < Depth; i++) begin : g_cell
    lob_pkg::cell_t left_c, right_c;
    logic           left_a;
    if (i == 0) begin : g_first
      assign left_c = '0;
      assign left_a = 1'b1;
    end else begin : g_mid
      assign left_c = cells[i-1];
      assign left_a = after[i-1];
    end
    if (i == Depth - 1) begin : g_last
      assign right_c = '0;
    end else begin : g_inner
      assign right_c = cells[i+1];
    end
    lob_cell u_cell (
      .clk_i        (clk_i),
      .rst_ni       (rst_ni),
      .ctrl_i       (ctrl_i),
      .is_head_i    (i == 0),
      .left_i       (left_c),
      .left_after_i (left_a),
      .right_i      (right_c),
      .cell_o       (cells[i]),
      .after_o      (after[i])
    );
  end

  assign head_o = cells[0];
  assign full_o = cells[Depth-1].valid;

endmodule
`default_nettype wire

FILE: design/limit_order_book_matcher_core.sv
// Top level of the limit order book matcher: two sorted cell chains and the match walk.
// Depends on lob_pkg, lob_side and lob_cell.
//
// One command at a time. A rest is accepted, inserted into the cell chain and its
// result beat loaded into the output register. A match walks one resting order per
// cycle, buffering fills in a 32-entry memory, then emits one fill beat per cycle
// while the output is not stalled. The next command is taken once the last result
// beat is loaded into the output register.
`default_nettype none
module limit_order_book_matcher_core #(
  parameter int unsigned BOOK_DEPTH = 32
) (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         s_axis_tvalid_i,
  output logic              s_axis_tready_o,
  // order_id[30:0], limit_price[62:31], order_quantity[86:63], zero pad[87]
  input  wire logic [87:0]  s_axis_tdata_i,
  // command[0], side[1]
  input  wire logic [1:0]   s_axis_tuser_i,
  output logic              m_axis_tvalid_o,
  input  wire logic         m_axis_tready_i,
  // buyer_id[30:0], seller_id[61:31], fill_price[93:62], fill_quantity[117:94],
  // aggressor_side[118], best_bid[150:119], best_ask[182:151], zero pad[183]
  output logic [183:0]      m_axis_tdata_o,
  // result_kind[1:0]
  output logic [1:0]        m_axis_tuser_o,
  output logic              m_axis_tlast_o
);

  lob_pkg::state_e state_q, state_d;
  logic                             cmd_q, side_q;
  logic [lob_pkg::IdW-1:0]          id_q;
  logic [lob_pkg::PriceW-1:0]       price_q;
  logic [lob_pkg::QtyW-1:0]         rem_q;
  logic [lob_pkg::FillCntW-1:0]     nfill_q, rd_q;
  lob_pkg::kind_e                   kind_q;
  lob_pkg::fill_t                   fill_mem [lob_pkg::MaxFills];

  logic                             out_valid_q;
  lob_pkg::kind_e                   out_kind_q;
  lob_pkg::fill_t                   out_fill_q;
  logic [lob_pkg::PriceW-1:0]       out_bid_q, out_ask_q;
  logic                             out_last_q;

  lob_pkg::cell_ctrl_t bid_ctrl, ask_ctrl;
  lob_pkg::cell_t      bid_head, ask_head, opp;
  logic                bid_full, ask_full;
  logic                in_acc, out_free, crossed, walk_go, pop, dec, emit_last;
  logic [lob_pkg::QtyW-1:0] m_qty;
  lob_pkg::fill_t      new_fill;
  logic [lob_pkg::PriceW-1:0] best_bid, best_ask;

  assign s_axis_tready_o = (state_q == lob_pkg::StIdle);
  assign in_acc   = s_axis_tvalid_i && s_axis_tready_o;
  assign out_free = !out_valid_q || m_axis_tready_i;

  assign opp     = (side_q == lob_pkg::SideBuy) ? ask_head : bid_head;
  assign crossed = (side_q == lob_pkg::SideBuy) ? (price_q >= opp.price)
                                                : (price_q <= opp.price);
  assign walk_go = (state_q == lob_pkg::StWalk) && opp.valid && (rem_q != '0) &&
                   (nfill_q != lob_pkg::FillCntW'(lob_pkg::MaxFills)) && crossed;
  assign m_qty   = (rem_q < opp.qty) ? rem_q : opp.qty;
  assign pop     = walk_go && (opp.qty == m_qty);
  assign dec     = walk_go && !pop;

  assign new_fill.buyer  = (side_q == lob_pkg::SideBuy) ? id_q : opp.id;
  assign new_fill.seller = (side_q == lob_pkg::SideBuy) ? opp.id : id_q;
  assign new_fill.price  = opp.price;
  assign new_fill.qty    = m_qty;
  assign new_fill.aggr   = side_q;

  assign best_bid  = bid_head.valid ? bid_head.price : '0;
  assign best_ask  = ask_head.valid ? ask_head.price : '0;
  assign emit_last = (rd_q == nfill_q - lob_pkg::FillCntW'(1));

  always_comb begin
    bid_ctrl.ins     = (state_q == lob_pkg::StIns) && (side_q == lob_pkg::SideBuy) &&
                       !bid_full;
    bid_ctrl.pop     = pop && (side_q == lob_pkg::SideSell);
    bid_ctrl.dec     = dec && (side_q == lob_pkg::SideSell);
    bid_ctrl.is_bid  = 1'b1;
    bid_ctrl.price   = price_q;
    bid_ctrl.qty     = rem_q;
    bid_ctrl.id      = id_q;
    bid_ctrl.dec_qty = m_qty;
    ask_ctrl         = bid_ctrl;
    ask_ctrl.ins     = (state_q == lob_pkg::StIns) && (side_q == lob_pkg::SideSell) &&
                       !ask_full;
    ask_ctrl.pop     = pop && (side_q == lob_pkg::SideBuy);
    ask_ctrl.dec     = dec && (side_q == lob_pkg::SideBuy);
    ask_ctrl.is_bid  = 1'b0;
  end

  lob_side #(.Depth(BOOK_DEPTH)) u_bid (
    .clk_i (clk_i), .rst_ni (rst_ni), .ctrl_i (bid_ctrl),
    .head_o (bid_head), .full_o (bid_full)
  );

  lob_side #(.Depth(BOOK_DEPTH)) u_ask (
    .clk_i (clk_i), .rst_ni (rst_ni), .ctrl_i (ask_ctrl),
    .head_o (ask_head), .full_o (ask_full)
  );

  always_comb begin
    state_d = state_q;
    case (state_q)
      lob_pkg::StIdle: if (in_acc) begin
        state_d = (s_axis_tuser_i[0] == lob_pkg::CmdRest) ? lob_pkg::StIns
                                                          : lob_pkg::StWalk;
      end
      lob_pkg::StIns:  state_d = lob_pkg::StFin;
      lob_pkg::StWalk: if (!walk_go) begin
        state_d = (nfill_q == '0) ? lob_pkg::StFin : lob_pkg::StEmit;
      end else if (dec) begin
        state_d = lob_pkg::StEmit;
      end
      lob_pkg::StEmit: if (out_free && emit_last) begin
        state_d = lob_pkg::StIdle;
      end
      lob_pkg::StFin:  if (out_free) begin
        state_d = lob_pkg::StIdle;
      end
      default:         state_d = lob_pkg::StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= lob_pkg::StIdle;
      out_valid_q <= 1'b0;
      nfill_q     <= '0;
      rd_q        <= '0;
    end else begin
      state_q <= state_d;
      if (in_acc) begin
        nfill_q <= '0;
        rd_q    <= '0;
      end else if (walk_go) begin
        nfill_q <= nfill_q + lob_pkg::FillCntW'(1);
      end else if ((state_q == lob_pkg::StEmit) && out_free) begin
        rd_q <= rd_q + lob_pkg::FillCntW'(1);
      end
      if (((state_q == lob_pkg::StEmit) || (state_q == lob_pkg::StFin)) && out_free) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      cmd_q   <= s_axis_tuser_i[0];
      side_q  <= s_axis_tuser_i[1];
      id_q    <= s_axis_tdata_i[30:0];
      price_q <= s_axis_tdata_i[62:31];
      rem_q   <= s_axis_tdata_i[86:63];
    end else if (walk_go) begin
      rem_q <= rem_q - m_qty;
    end
    if (state_q == lob_pkg::StIns) begin
      kind_q <= ((side_q == lob_pkg::SideBuy) ? bid_full : ask_full) ?
                lob_pkg::KindReject : lob_pkg::KindRested;
    end else if (state_q == lob_pkg::StWalk) begin
      kind_q <= (cmd_q == lob_pkg::CmdMatch) ? lob_pkg::KindNoFill : lob_pkg::KindRested;
    end
    if (walk_go) begin
      fill_mem[nfill_q[lob_pkg::FillIdxW-1:0]] <= new_fill;
    end
    if ((state_q == lob_pkg::StEmit) && out_free) begin
      out_kind_q <= lob_pkg::KindFill;
      out_fill_q <= fill_mem[rd_q[lob_pkg::FillIdxW-1:0]];
      out_last_q <= emit_last;
      out_bid_q  <= best_bid;
      out_ask_q  <= best_ask;
    end else if ((state_q == lob_pkg::StFin) && out_free) begin
      out_kind_q <= kind_q;
      out_fill_q <= '0;
      out_last_q <= 1'b1;
      out_bid_q  <= best_bid;
      out_ask_q  <= best_ask;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tuser_o  = out_kind_q;
  assign m_axis_tlast_o  = out_last_q;
  assign m_axis_tdata_o  = {1'b0, out_ask_q, out_bid_q, out_fill_q.aggr, out_fill_q.qty,
                            out_fill_q.price, out_fill_q.seller, out_fill_q.buyer};

endmodule
`default_nettype wire

FILE: design/lob_checker.sv
// Port-level checks for limit_order_book_matcher_core, attached with bind.
// Depends on lob_pkg.
`default_nettype none
module lob_checker (
  input wire logic         clk_i,
  input wire logic         rst_ni,
  input wire logic         s_axis_tvalid_i,
  input wire logic         s_axis_tready_o,
  input wire logic         m_axis_tvalid_o,
  input wire logic         m_axis_tready_i,
  input wire logic [183:0] m_axis_tdata_o,
  input wire logic [1:0]   m_axis_tuser_o,
  input wire logic         m_axis_tlast_o
);

  logic non_fill;
  assign non_fill = m_axis_tvalid_o && (m_axis_tuser_o != lob_pkg::KindFill);

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=> m_axis_tvalid_o && $stable(m_axis_tdata_o))
    else $error("output beat changed while stalled");

  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid_i && s_axis_tready_o |=> !s_axis_tready_o)
    else $error("second command taken during work");

  a_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    non_fill |-> m_axis_tlast_o)
    else $error("non-fill result not last");

  a_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    non_fill |-> (m_axis_tdata_o[118:0] == '0))
    else $error("non-fill result carries fill fields");

endmodule

bind limit_order_book_matcher_core lob_checker u_lob_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .s_axis_tvalid_i (s_axis_tvalid_i),
  .s_axis_tready_o (s_axis_tready_o),
  .m_axis_tvalid_o (m_axis_tvalid_o),
  .m_axis_tready_i (m_axis_tready_i),
  .m_axis_tdata_o  (m_axis_tdata_o),
  .m_axis_tuser_o  (m_axis_tuser_o),
  .m_axis_tlast_o  (m_axis_tlast_o)
);
`default_nettype wire

FILE: dv/tb_top.sv
// Testbench for limit_order_book_matcher_core: directed and random order streams.
// Predicts fills and book tops with its own sorted book model; depends on lob_pkg.
`timescale 1ns / 100ps
module tb_top;

  localparam int Depth = 32;

  typedef struct {
    logic [1:0]                 kind;
    logic [lob_pkg::IdW-1:0]    buyer;
    logic [lob_pkg::IdW-1:0]    seller;
    logic [lob_pkg::PriceW-1:0] price;
    logic [lob_pkg::QtyW-1:0]   qty;
    logic                       aggr;
    logic [lob_pkg::PriceW-1:0] bid;
    logic [lob_pkg::PriceW-1:0] ask;
    logic                       last;
  } result_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic s_axis_tvalid_i = 1'b0;
  logic s_axis_tready_o;
  logic [87:0] s_axis_tdata_i = '0;
  logic [1:0] s_axis_tuser_i = '0;
  logic m_axis_tvalid_o;
  logic m_axis_tready_i = 1'b0;
  logic [183:0] m_axis_tdata_o;
  logic [1:0] m_axis_tuser_o;
  logic m_axis_tlast_o;

  limit_order_book_matcher_core #(.BOOK_DEPTH(Depth)) dut (.*);

  initial forever #5 clk_i = ~clk_i;

  // book model: index 0 is best
  logic [lob_pkg::PriceW-1:0] bid_px[$], ask_px[$];
  logic [lob_pkg::QtyW-1:0]   bid_qt[$], ask_qt[$];
  logic [lob_pkg::IdW-1:0]    bid_id[$], ask_id[$];
  result_t fills_due[$];
  int errors = 0;
  bit gaps_on = 1'b1;
  bit hold_rx = 1'b0;

  function automatic logic [lob_pkg::PriceW-1:0] top_bid();
    return bid_px.size() ? bid_px[0] : '0;
  endfunction
  function automatic logic [lob_pkg::PriceW-1:0] top_ask();
    return ask_px.size() ? ask_px[0] : '0;
  endfunction

  task automatic predict_order(logic cmd, logic sd, logic [lob_pkg::IdW-1:0] id,
                               logic [lob_pkg::PriceW-1:0] px,
                               logic [lob_pkg::QtyW-1:0] qt);
    result_t step[$];
    result_t r;
    int pos;
    logic [lob_pkg::QtyW-1:0] rem, m;
    logic [lob_pkg::PriceW-1:0] rp;
    step = {};
    r = '{default: '0};
    if (cmd == lob_pkg::CmdRest) begin
      if (sd == lob_pkg::SideBuy) begin
        if (bid_px.size() >= Depth) r.kind = lob_pkg::KindReject;
        else begin
          pos = 0;
          while (pos < bid_px.size() && bid_px[pos] >= px) pos++;
          bid_px.insert(pos, px); bid_qt.insert(pos, qt); bid_id.insert(pos, id);
          r.kind = lob_pkg::KindRested;
        end
      end else begin
        if (ask_px.size() >= Depth) r.kind = lob_pkg::KindReject;
        else begin
          pos = 0;
          while (pos < ask_px.size() && ask_px[pos] <= px) pos++;
          ask_px.insert(pos, px); ask_qt.insert(pos, qt); ask_id.insert(pos, id);
          r.kind = lob_pkg::KindRested;
        end
      end
      step.insert(step.size(), r);
    end else begin
      rem = qt;
      while (rem > 0 && step.size() < lob_pkg::MaxFills) begin
        r = '{default: '0};
        r.kind = lob_pkg::KindFill;
        if (sd == lob_pkg::SideBuy) begin
          if (ask_px.size() == 0 || px < ask_px[0]) break;
          rp = ask_px[0];
          m = (rem < ask_qt[0]) ? rem : ask_qt[0];
          r.buyer = id; r.seller = ask_id[0]; r.aggr = lob_pkg::SideBuy;
          ask_qt[0] -= m;
        end else begin
          if (bid_px.size() == 0 || px > bid_px[0]) break;
          rp = bid_px[0];
          m = (rem < bid_qt[0]) ? rem : bid_qt[0];
          r.buyer = bid_id[0]; r.seller = id; r.aggr = lob_pkg::SideSell;
          bid_qt[0] -= m;
        end
        r.price = rp; r.qty = m;
        step.insert(step.size(), r);
        rem -= m;
        if (sd == lob_pkg::SideBuy) begin
          if (ask_qt[0] != 0) break;
          void'(ask_px.pop_front()); void'(ask_qt.pop_front()); void'(ask_id.pop_front());
        end else begin
          if (bid_qt[0] != 0) break;
          void'(bid_px.pop_front()); void'(bid_qt.pop_front()); void'(bid_id.pop_front());
        end
      end
      if (step.size() == 0) begin
        r = '{default: '0};
        r.kind = lob_pkg::KindNoFill;
        step.insert(step.size(), r);
      end
    end
    foreach (step[k]) begin
      step[k].bid = top_bid();
      step[k].ask = top_ask();
      step[k].last = (k == step.size() - 1);
      fills_due.insert(fills_due.size(), step[k]);
    end
  endtask

  task automatic send_order(logic cmd, logic sd, logic [lob_pkg::IdW-1:0] id,
                            logic [lob_pkg::PriceW-1:0] px,
                            logic [lob_pkg::QtyW-1:0] qt);
    int gap;
    if (gaps_on && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 11);
      s_axis_tvalid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tuser_i <= {sd, cmd};
    s_axis_tdata_i <= {1'b0, qt, px, id};
    @(posedge clk_i);
    while (!s_axis_tready_o) @(posedge clk_i);
    predict_order(cmd, sd, id, px, qt);
    @(negedge clk_i);
  endtask

  task automatic drain();
    s_axis_tvalid_i <= 1'b0;
    while (fills_due.size() != 0) @(negedge clk_i);
    repeat (8) @(negedge clk_i);
  endtask

  // receiver
  initial begin
    int gap;
    forever begin
      @(negedge clk_i);
      if (hold_rx) m_axis_tready_i <= 1'b0;
      else if (gaps_on && $urandom_range(0, 5) == 0) begin
        gap = $urandom_range(1, 11);
        m_axis_tready_i <= 1'b0;
        repeat (gap - 1) @(negedge clk_i);
      end else m_axis_tready_i <= 1'b1;
    end
  end

  // checker
  initial begin
    result_t e;
    forever begin
      @(posedge clk_i);
      if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
        if (fills_due.size() == 0) begin
          $error("unexpected beat kind=%0d", m_axis_tuser_o);
          errors++;
        end else begin
          e = fills_due.pop_front();
          if (m_axis_tuser_o !== e.kind) begin
            $error("result_kind exp %0d got %0d", e.kind, m_axis_tuser_o); errors++;
          end
          if (m_axis_tdata_o[30:0] !== e.buyer) begin
            $error("buyer_id exp %0d got %0d", e.buyer, m_axis_tdata_o[30:0]); errors++;
          end
          if (m_axis_tdata_o[61:31] !== e.seller) begin
            $error("seller_id exp %0d got %0d", e.seller, m_axis_tdata_o[61:31]); errors++;
          end
          if (m_axis_tdata_o[93:62] !== e.price) begin
            $error("fill_price exp %0d got %0d", e.price, m_axis_tdata_o[93:62]); errors++;
          end
          if (m_axis_tdata_o[117:94] !== e.qty) begin
            $error("fill_quantity exp %0d got %0d", e.qty, m_axis_tdata_o[117:94]);
            errors++;
          end
          if (m_axis_tdata_o[118] !== e.aggr) begin
            $error("aggressor_side exp %0d got %0d", e.aggr, m_axis_tdata_o[118]); errors++;
          end
          if (m_axis_tdata_o[150:119] !== e.bid) begin
            $error("best_bid exp %0d got %0d", e.bid, m_axis_tdata_o[150:119]); errors++;
          end
          if (m_axis_tdata_o[182:151] !== e.ask) begin
            $error("best_ask exp %0d got %0d", e.ask, m_axis_tdata_o[182:151]); errors++;
          end
          if (m_axis_tlast_o !== e.last) begin
            $error("last exp %0d got %0d", e.last, m_axis_tlast_o); errors++;
          end
        end
      end
    end
  end

  function automatic logic [lob_pkg::IdW-1:0] rand_id();
    return lob_pkg::IdW'($urandom());
  endfunction

  task automatic test_directed();
    send_order(lob_pkg::CmdMatch, lob_pkg::SideBuy, 31'h7fff_ffff, 32'hffff_ffff,
               24'hff_ffff);
    send_order(lob_pkg::CmdMatch, lob_pkg::SideSell, 31'd0, 32'd0, 24'hff_ffff);
    send_order(lob_pkg::CmdRest, lob_pkg::SideBuy, 31'h7fff_ffff, 32'hffff_ffff,
               24'hff_ffff);
    send_order(lob_pkg::CmdRest, lob_pkg::SideBuy, 31'd1, 32'd100, 24'd0);
    send_order(lob_pkg::CmdRest, lob_pkg::SideBuy, 31'd2, 32'd100, 24'd5);
    send_order(lob_pkg::CmdRest, lob_pkg::SideSell, 31'd3, 32'd200, 24'd7);
    send_order(lob_pkg::CmdRest, lob_pkg::SideSell, 31'd4, 32'd200, 24'd0);
    send_order(lob_pkg::CmdRest, lob_pkg::SideSell, 31'd5, 32'd0, 24'd3);
    send_order(lob_pkg::CmdMatch, lob_pkg::SideBuy, 31'd6, 32'd50, 24'd0);
    send_order(lob_pkg::CmdMatch, lob_pkg::SideBuy, 31'd7, 32'd50, 24'd10);
    send_order(lob_pkg::CmdMatch, lob_pkg::SideBuy, 31'd8, 32'd10, 24'd2);
    send_order(lob_pkg::CmdMatch, lob_pkg::SideSell, 31'd9, 32'd0, 24'hff_ffff);
    send_order(lob_pkg::CmdMatch, lob_pkg::SideSell, 31'd10, 32'd100, 24'd3);
    send_order(lob_pkg::CmdMatch, lob_pkg::SideBuy, 31'd11, 32'd200, 24'hff_ffff);
    drain();
  endtask

  // fill each side, reject, then sweep it with a match capped at the fill limit
  task automatic test_full_book();
    for (int i = 0; i <= Depth; i++)
      send_order(lob_pkg::CmdRest, lob_pkg::SideSell, rand_id(),
                 32'($urandom_range(1000, 1040)), 24'd1);
    send_order(lob_pkg::CmdMatch, lob_pkg::SideBuy, rand_id(), 32'hffff_ffff, 24'hff_ffff);
    for (int i = 0; i <= Depth; i++)
      send_order(lob_pkg::CmdRest, lob_pkg::SideBuy, rand_id(),
                 32'($urandom_range(1000, 1040)), 24'($urandom_range(0, 2)));
    send_order(lob_pkg::CmdMatch, lob_pkg::SideSell, rand_id(), 32'd0, 24'hff_ffff);
    drain();
  endtask

  // hold the receiver off while orders keep coming
  task automatic test_backpressure();
    hold_rx = 1'b1;
    fork
      for (int i = 0; i < 12; i++)
        send_order(1'(i % 2), 1'($urandom_range(0, 1)), rand_id(),
                   32'($urandom_range(90, 110)), 24'($urandom_range(1, 20)));
      repeat (300) @(negedge clk_i);
    join_any
    hold_rx = 1'b0;
    wait fork;
    drain();
  endtask

  task automatic test_random(int n);
    logic cmd, sd;
    logic [lob_pkg::PriceW-1:0] px;
    logic [lob_pkg::QtyW-1:0] qt;
    for (int i = 0; i < n; i++) begin
      if (i > n * 3 / 4) gaps_on = 1'b0;
      cmd = ($urandom_range(0, 9) < 6) ? lob_pkg::CmdRest : lob_pkg::CmdMatch;
      sd = 1'($urandom_range(0, 1));
      case ($urandom_range(0, 9))
        0: px = $urandom();
        1: px = sd ? 32'hffff_ffff : 32'h0;
        default: px = 32'($urandom_range(480, 520));
      endcase
      case ($urandom_range(0, 9))
        0: qt = 24'($urandom());
        1: qt = '0;
        default: qt = 24'($urandom_range(1, 60));
      endcase
      send_order(cmd, sd, rand_id(), px, qt);
      if (i == n / 2) drain();
    end
    drain();
  endtask

  initial begin
    repeat (2) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);
    test_directed();
    test_full_book();
    test_backpressure();
    test_random(230);
    if (errors == 0) $display("tb_top: done, clean");
    else $display("tb_top: done, errors");
    $finish;
  end

  initial begin
    #20ms;
    $display("tb_top: done, errors");
    $finish;
  end
endmodule

FILE: limit_order_book_matcher_core.f
design/lob_pkg.sv
design/lob_cell.sv
design/lob_side.sv
design/limit_order_book_matcher_core.sv
design/lob_checker.sv
dv/tb_top.sv
